// ===== rtl/mcu_pkg.sv =====
`default_nettype none
package mcu_pkg;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int PC_W        = 13;

  localparam int FLAG_C  = 0;
  localparam int FLAG_DC = 1;
  localparam int FLAG_Z  = 2;
  localparam int GIE_BIT = 7;

  localparam logic [13:0]     INS_RETURN = 14'h0008;
  localparam logic [13:0]     INS_RETFIE = 14'h0009;
  localparam logic [PC_W-1:0] IRQ_VECTOR = 13'h0004;

  localparam logic [1:0] STACK_NONE  = 2'd0;
  localparam logic [1:0] STACK_OVER  = 2'd1;
  localparam logic [1:0] STACK_UNDER = 2'd2;

  typedef enum logic [1:0] {
    CLS_BYTE = 2'd0,
    CLS_BIT  = 2'd1,
    CLS_JUMP = 2'd2,
    CLS_LIT  = 2'd3
  } ins_class_e;

  typedef enum logic [3:0] {
    BYTE_MISC   = 4'h0,
    BYTE_CLR    = 4'h1,
    BYTE_SUBWF  = 4'h2,
    BYTE_DECF   = 4'h3,
    BYTE_IORWF  = 4'h4,
    BYTE_ANDWF  = 4'h5,
    BYTE_XORWF  = 4'h6,
    BYTE_ADDWF  = 4'h7,
    BYTE_MOVF   = 4'h8,
    BYTE_COMF   = 4'h9,
    BYTE_INCF   = 4'hA,
    BYTE_DECFSZ = 4'hB,
    BYTE_RRF    = 4'hC,
    BYTE_RLF    = 4'hD,
    BYTE_SWAPF  = 4'hE,
    BYTE_INCFSZ = 4'hF
  } byte_op_e;

  typedef enum logic [1:0] {
    BOP_BCF   = 2'd0,
    BOP_BSF   = 2'd1,
    BOP_BTFSC = 2'd2,
    BOP_BTFSS = 2'd3
  } bit_op_e;

  typedef enum logic [3:0] {
    LIT_MOVLW_0 = 4'h0,
    LIT_MOVLW_1 = 4'h1,
    LIT_MOVLW_2 = 4'h2,
    LIT_MOVLW_3 = 4'h3,
    LIT_RETLW_0 = 4'h4,
    LIT_RETLW_1 = 4'h5,
    LIT_RETLW_2 = 4'h6,
    LIT_RETLW_3 = 4'h7,
    LIT_IORLW   = 4'h8,
    LIT_ANDLW   = 4'h9,
    LIT_XORLW   = 4'hA,
    LIT_RSVD    = 4'hB,
    LIT_SUBLW_0 = 4'hC,
    LIT_SUBLW_1 = 4'hD,
    LIT_ADDLW_0 = 4'hE,
    LIT_ADDLW_1 = 4'hF
  } lit_op_e;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic [PC_W-1:0] push_pc;
    logic            irq_push;
    logic [PC_W-1:0] irq_pc;
  } stack_req_t;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic [7:0]      w;
    logic            fw;
    logic [6:0]      fa;
    logic [7:0]      fd;
    logic [7:0]      st;
    logic [7:0]      ic;
  } exec_res_t;

endpackage
`default_nettype wire

// ===== rtl/mcu_exec.sv =====
`default_nettype none
module mcu_exec (
  input  logic [13:0]                 ins_i,
  input  logic [7:0]                  file_i,
  input  logic [7:0]                  status_i,
  input  logic [7:0]                  intcon_i,
  input  logic [7:0]                  pclath_i,
  input  logic                        irq_i,
  input  logic [7:0]                  w_i,
  input  logic [mcu_pkg::PC_W-1:0]    pc_i,
  input  logic [mcu_pkg::PC_W-1:0]    pop_pc_i,
  output mcu_pkg::stack_req_t         req_o,
  output mcu_pkg::exec_res_t          res_o
);
  import mcu_pkg::*;

  logic [7:0]      f, w, k, r, bsel, st, ic, w_n, data;
  logic [PC_W-1:0] pc_inc, pc_n;
  logic [8:0]      sum9;
  logic [4:0]      nib5;
  logic            d, wr, keep;

  assign f      = file_i;
  assign w      = w_i;
  assign k      = ins_i[7:0];
  assign d      = ins_i[7];
  assign pc_inc = pc_i + PC_W'(1);
  assign bsel   = 8'b1 << ins_i[9:7];

  always_comb begin
    pc_n = pc_inc;
    w_n  = w;
    wr   = 1'b0;
    data = 8'h00;
    st   = status_i;
    ic   = intcon_i;
    r    = 8'h00;
    keep = 1'b1;
    sum9 = 9'h000;
    nib5 = 5'h00;
    req_o = '0;
    req_o.push_pc = pc_inc;
    unique case (ins_class_e'(ins_i[13:12]))
      CLS_BYTE: begin
        unique case (byte_op_e'(ins_i[11:8]))
          BYTE_MISC: begin
            keep = 1'b0;
            if (ins_i == INS_RETURN) begin
              req_o.pop = 1'b1;
              pc_n = pop_pc_i;
            end else if (ins_i == INS_RETFIE) begin
              ic[GIE_BIT] = 1'b1;
              req_o.pop = 1'b1;
              pc_n = pop_pc_i;
            end else if (d) begin
              wr   = 1'b1;
              data = w;
            end
          end
          BYTE_CLR: begin
            keep = 1'b0;
            st[FLAG_Z] = 1'b1;
            if (d) begin
              wr   = 1'b1;
              data = 8'h00;
            end else begin
              w_n = 8'h00;
            end
          end
          BYTE_SUBWF: begin
            r = f - w;
            st[FLAG_C]  = f >= w;
            st[FLAG_DC] = f[3:0] >= w[3:0];
            st[FLAG_Z]  = r == 8'h00;
          end
          BYTE_DECF: begin
            r = f - 8'd1;
            st[FLAG_Z] = r == 8'h00;
          end
          BYTE_IORWF: begin
            r = f | w;
            st[FLAG_Z] = r == 8'h00;
          end
          BYTE_ANDWF: begin
            r = f & w;
            st[FLAG_Z] = r == 8'h00;
          end
          BYTE_XORWF: begin
            r = f ^ w;
            st[FLAG_Z] = r == 8'h00;
          end
          BYTE_ADDWF: begin
            sum9 = {1'b0, f} + {1'b0, w};
            nib5 = {1'b0, f[3:0]} + {1'b0, w[3:0]};
            r = sum9[7:0];
            st[FLAG_C]  = sum9[8];
            st[FLAG_DC] = nib5[4];
            st[FLAG_Z]  = r == 8'h00;
          end
          BYTE_MOVF: begin
            r = f;
            st[FLAG_Z] = r == 8'h00;
            keep = !d;
          end
          BYTE_COMF: begin
            r = ~f;
            st[FLAG_Z] = r == 8'h00;
          end
          BYTE_INCF: begin
            r = f + 8'd1;
            st[FLAG_Z] = r == 8'h00;
          end
          BYTE_DECFSZ: begin
            r = f - 8'd1;
            if (r == 8'h00) pc_n = pc_inc + PC_W'(1);
          end
          BYTE_RRF: begin
            r = {status_i[FLAG_C], f[7:1]};
            st[FLAG_C] = f[0];
          end
          BYTE_RLF: begin
            r = {f[6:0], status_i[FLAG_C]};
            st[FLAG_C] = f[7];
          end
          BYTE_SWAPF: begin
            r = {f[3:0], f[7:4]};
          end
          BYTE_INCFSZ: begin
            r = f + 8'd1;
            if (r == 8'h00) pc_n = pc_inc + PC_W'(1);
          end
        endcase
        if (keep) begin
          if (d) begin
            wr   = 1'b1;
            data = r;
          end else begin
            w_n = r;
          end
        end
      end
      CLS_BIT: begin
        unique case (bit_op_e'(ins_i[11:10]))
          BOP_BCF: begin
            wr   = 1'b1;
            data = f & ~bsel;
          end
          BOP_BSF: begin
            wr   = 1'b1;
            data = f | bsel;
          end
          BOP_BTFSC: if ((f & bsel) == 8'h00) pc_n = pc_inc + PC_W'(1);
          BOP_BTFSS: if ((f & bsel) != 8'h00) pc_n = pc_inc + PC_W'(1);
        endcase
      end
      CLS_JUMP: begin
        req_o.push = !ins_i[11];
        pc_n = {pclath_i[4:3], ins_i[10:0]};
      end
      CLS_LIT: begin
        unique case (lit_op_e'(ins_i[11:8]))
          LIT_MOVLW_0, LIT_MOVLW_1, LIT_MOVLW_2, LIT_MOVLW_3: w_n = k;
          LIT_RETLW_0, LIT_RETLW_1, LIT_RETLW_2, LIT_RETLW_3: begin
            w_n = k;
            req_o.pop = 1'b1;
            pc_n = pop_pc_i;
          end
          LIT_IORLW: begin
            w_n = w | k;
            st[FLAG_Z] = w_n == 8'h00;
          end
          LIT_ANDLW: begin
            w_n = w & k;
            st[FLAG_Z] = w_n == 8'h00;
          end
          LIT_XORLW: begin
            w_n = w ^ k;
            st[FLAG_Z] = w_n == 8'h00;
          end
          LIT_RSVD: w_n = w;
          LIT_SUBLW_0, LIT_SUBLW_1: begin
            w_n = k - w;
            st[FLAG_C]  = k >= w;
            st[FLAG_DC] = k[3:0] >= w[3:0];
            st[FLAG_Z]  = w_n == 8'h00;
          end
          LIT_ADDLW_0, LIT_ADDLW_1: begin
            sum9 = {1'b0, k} + {1'b0, w};
            nib5 = {1'b0, k[3:0]} + {1'b0, w[3:0]};
            w_n = sum9[7:0];
            st[FLAG_C]  = sum9[8];
            st[FLAG_DC] = nib5[4];
            st[FLAG_Z]  = w_n == 8'h00;
          end
        endcase
      end
    endcase
    req_o.irq_pc = pc_n;
    if (irq_i) begin
      ic[GIE_BIT]    = 1'b0;
      req_o.irq_push = 1'b1;
      pc_n           = IRQ_VECTOR;
    end
    res_o.pc = pc_n;
    res_o.w  = w_n;
    res_o.fw = wr;
    res_o.fa = wr ? ins_i[6:0] : 7'h00;
    res_o.fd = wr ? data : 8'h00;
    res_o.st = st;
    res_o.ic = ic;
  end

endmodule
`default_nettype wire

// ===== rtl/mcu_stack.sv =====
`default_nettype none
module mcu_stack #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  mcu_pkg::stack_req_t      req_i,
  output logic [mcu_pkg::PC_W-1:0] pop_pc_o,
  output logic [1:0]               event_o
);
  import mcu_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [LVL_W-1:0] FULL = LVL_W'(STACK_DEPTH);

  logic [PC_W-1:0]  stack_q [STACK_DEPTH];
  logic [LVL_W-1:0] level_q, level_d;
  logic [LVL_W-1:0] rd_lvl, lvl1, base1, base2;
  logic [1:0]       ev1, ev2;

  always_comb begin
    rd_lvl = (level_q == '0) ? FULL : level_q;
    lvl1   = level_q;
    base1  = (level_q == FULL) ? '0 : level_q;
    ev1    = STACK_NONE;
    if (req_i.pop) begin
      lvl1 = rd_lvl - LVL_W'(1);
      if (level_q == '0) ev1 = STACK_UNDER;
    end else if (req_i.push) begin
      lvl1 = base1 + LVL_W'(1);
      if (level_q == FULL) ev1 = STACK_OVER;
    end
    base2   = (lvl1 == FULL) ? '0 : lvl1;
    ev2     = STACK_NONE;
    level_d = lvl1;
    if (req_i.irq_push) begin
      level_d = base2 + LVL_W'(1);
      if (lvl1 == FULL) ev2 = STACK_OVER;
    end
    event_o = (ev1 != STACK_NONE) ? ev1 : ev2;
  end

  assign pop_pc_o = stack_q[IDX_W'(rd_lvl - LVL_W'(1))];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (fire_i) begin
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && req_i.push && !req_i.pop) begin
      stack_q[IDX_W'(base1)] <= req_i.push_pc;
    end
    if (fire_i && req_i.irq_push) begin
      stack_q[IDX_W'(base2)] <= req_i.irq_pc;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/midrange_8bit_mcu_core_step.sv =====
// Channel | Dir | Bits | Word contents
// s_axis  | in  | 48   | instruction, file value, STATUS, INTCON, PCLATH, interrupt
// m_axis  | out | 56   | next PC, W, file write, address, data, STATUS, INTCON, event
//
// Path: input register, one execute pass, result register.
// One word per cycle unless the result stalls; W, PC and return stack update on execute.
// Reset clears PC and stack level; W and stack entries hold until written.
// A stalled result holds the execute stage; one more word waits in the input register.
`default_nettype none
module midrange_8bit_mcu_core_step #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // instruction_word, file_value, status_value, intcon_value, pclath_value,
  // interrupt_pending, pad
  input  logic [mcu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // next_pc, w_out, file_write, file_address, file_data, status_out,
  // intcon_out, stack_event, pad
  output logic [mcu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import mcu_pkg::*;

  logic                  in_valid_q, out_valid_q, exec_fire;
  logic [IN_TDATA_W-1:0] in_data_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [7:0]            w_q;
  logic [PC_W-1:0]       pc_q;
  logic [PC_W-1:0]       pop_pc;
  logic [1:0]            stack_ev;
  stack_req_t            req;
  exec_res_t             res;

  assign exec_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || exec_fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  mcu_exec u_exec (
    .ins_i    (in_data_q[13:0]),
    .file_i   (in_data_q[21:14]),
    .status_i (in_data_q[29:22]),
    .intcon_i (in_data_q[37:30]),
    .pclath_i (in_data_q[45:38]),
    .irq_i    (in_data_q[46]),
    .w_i      (w_q),
    .pc_i     (pc_q),
    .pop_pc_i (pop_pc),
    .req_o    (req),
    .res_o    (res)
  );

  mcu_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (exec_fire),
    .req_i    (req),
    .pop_pc_o (pop_pc),
    .event_o  (stack_ev)
  );

  assign out_data_d = {1'b0, stack_ev, res.ic, res.st, res.fd, res.fa, res.fw, res.w, res.pc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
        pc_q        <= res.pc;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_data_q <= s_axis_tdata;
    if (exec_fire) begin
      out_data_q <= out_data_d;
      w_q        <= res.w;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcu_checker.sv =====
`default_nettype none
module mcu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mcu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mcu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted word produced no result");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[21] |-> m_axis_tdata[36:22] == 15'h0000)
    else $error("address or data set without file write");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[54:53] == STACK_NONE || m_axis_tdata[54:53] == STACK_OVER
                      || m_axis_tdata[54:53] == STACK_UNDER)
    else $error("bad stack event code");

endmodule

bind midrange_8bit_mcu_core_step mcu_checker u_mcu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
